// ===== sv/epwr_pkg.sv =====
// Shared types, constants and codes of the echo pulse width ranger.
`default_nettype none

package epwr_pkg;

  // Block sizing.
  localparam int OVERFLOW_BITS = 6;
  localparam int COUNTER_WIDTH = 32;
  localparam int AVERAGE_COUNT = 3;

  // Field and datapath widths.
  localparam int CMD_W      = 2;
  localparam int CAPTURE_W  = 32;
  localparam int PERIOD_W   = 32;
  localparam int SCALE_W    = 16;
  localparam int FRAC_W     = 16;
  localparam int DIST_W     = 33;
  localparam int WEIGHT_W   = COUNTER_WIDTH + 1;
  localparam int TOTAL_W    = OVERFLOW_BITS + COUNTER_WIDTH;
  localparam int TOTAL_LO_W = TOTAL_W / 2;
  localparam int TOTAL_HI_W = TOTAL_W - TOTAL_LO_W;
  localparam int PROD_W     = TOTAL_W + SCALE_W;
  localparam int SHIFT_W    = PROD_W - FRAC_W;
  localparam int WIDE_W     = (SHIFT_W > DIST_W) ? SHIFT_W : DIST_W + 1;
  localparam int SUM_W      = DIST_W + $clog2(AVERAGE_COUNT);
  localparam int SCNT_W     = $clog2(AVERAGE_COUNT + 1);

  // The group mean is the sum times a rounded-up reciprocal of the group size,
  // shifted down. With the shift at SUM_W plus the size's bit count the error
  // term stays below one count for every sum that fits in SUM_W bits.
  localparam int AVG_SHIFT  = SUM_W + $clog2(AVERAGE_COUNT);
  localparam int RECIP_W    = SUM_W + 1;
  localparam int SUM_LO_W   = SUM_W / 2;
  localparam int SUM_HI_W   = SUM_W - SUM_LO_W;
  localparam int AVG_PROD_W = SUM_W + RECIP_W;
  localparam logic [63:0] AVG_RECIP_WIDE =
    ((64'd1 << AVG_SHIFT) + 64'(AVERAGE_COUNT - 1)) / 64'(AVERAGE_COUNT);
  localparam logic [RECIP_W-1:0] AVG_RECIP = RECIP_W'(AVG_RECIP_WIDE);

  // Job queue between the front and back parts.
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_TIMER_PERIOD   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DISTANCE_SCALE = 1'd1;
  localparam logic [PERIOD_W-1:0]  PERIOD_RESET = 32'hFFFF_FFFF;
  localparam logic [SCALE_W-1:0]   SCALE_RESET  = 16'd1114;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_OVERFLOW      = 2'd0;
  localparam logic [CMD_W-1:0] CMD_EDGE          = 2'd1;
  localparam logic [CMD_W-1:0] CMD_OVERFLOW_EDGE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NONE          = 2'd3;

  localparam logic [OVERFLOW_BITS-1:0] OVF_MAX  = '1;
  localparam logic [DIST_W-1:0]        DIST_MAX = '1;

  typedef struct packed {
    logic [CMD_W-1:0]     command;
    logic [CAPTURE_W-1:0] capture_value;
  } epwr_in_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              timed_out;
    logic [DIST_W-1:0] average;
    logic              average_valid;
  } epwr_out_t;

  // One finished measurement handed from the front to the back.
  typedef struct packed {
    logic                     timeout;
    logic [OVERFLOW_BITS-1:0] ovf_count;
    logic [COUNTER_WIDTH-1:0] capture;
  } epwr_job_t;

endpackage

`default_nettype wire

// ===== sv/epwr_front.sv =====
// Front part: accepts timer events, tracks arming and overflows, issues jobs.
`default_nettype none

module epwr_front import epwr_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire epwr_in_t  in_data,
  input  wire logic      q_full,
  output logic           q_push,
  output epwr_job_t      q_job
);

  logic                     armed_r, armed_nxt;
  logic [OVERFLOW_BITS-1:0] ovf_cnt_r, ovf_cnt_nxt;

  assign in_stall = q_full;

  always_comb begin
    logic                     ev_ovf;
    logic                     ev_edge;
    logic                     done;
    logic [OVERFLOW_BITS-1:0] cnt_tmp;
    ev_ovf  = 1'b0;
    ev_edge = 1'b0;
    done    = 1'b0;
    cnt_tmp = ovf_cnt_r;
    unique case (in_data.command)
      CMD_OVERFLOW:      ev_ovf = 1'b1;
      CMD_EDGE:          ev_edge = 1'b1;
      CMD_OVERFLOW_EDGE: begin
        ev_ovf  = 1'b1;
        ev_edge = 1'b1;
      end
      CMD_NONE:          ;
    endcase

    armed_nxt         = armed_r;
    ovf_cnt_nxt       = ovf_cnt_r;
    q_push            = 1'b0;
    q_job.timeout     = 1'b0;
    q_job.ovf_count   = ovf_cnt_r;
    q_job.capture     = in_data.capture_value[COUNTER_WIDTH-1:0];

    if (in_valid && !q_full) begin
      if (ev_ovf && armed_r) begin
        if (ovf_cnt_r == OVF_MAX) begin
          // Timeout: an edge in the same event belongs to the lost echo.
          q_push        = 1'b1;
          q_job.timeout = 1'b1;
          armed_nxt     = 1'b0;
          ovf_cnt_nxt   = '0;
          done          = 1'b1;
        end else begin
          cnt_tmp     = ovf_cnt_r + 1'b1;
          ovf_cnt_nxt = cnt_tmp;
        end
      end
      if (ev_edge && !done) begin
        if (armed_r) begin
          q_push          = 1'b1;
          q_job.ovf_count = cnt_tmp;
          armed_nxt       = 1'b0;
          ovf_cnt_nxt     = '0;
        end else begin
          armed_nxt   = 1'b1;
          ovf_cnt_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r   <= 1'b0;
      ovf_cnt_r <= '0;
    end else begin
      armed_r   <= armed_nxt;
      ovf_cnt_r <= ovf_cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/epwr_queue.sv =====
// Two-entry job queue that decouples the front part from the back part.
`default_nettype none

module epwr_queue import epwr_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire epwr_job_t push_job,
  output logic           full,
  input  wire logic      pop,
  output logic           not_empty,
  output epwr_job_t      head_job
);

  epwr_job_t            mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]   count_r, count_nxt;

  assign full      = (count_r == Q_CNT_W'(Q_DEPTH));
  assign not_empty = (count_r != '0);
  assign head_job  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    unique case ({push, pop})
      2'b10:        count_nxt = count_r + 1'b1;
      2'b01:        count_nxt = count_r - 1'b1;
      2'b00, 2'b11: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("job queue written while full");

  a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("job queue read while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= Q_CNT_W'(Q_DEPTH))
    else $error("job queue fill count beyond its depth");

endmodule

`default_nettype wire

// ===== sv/epwr_back.sv =====
// Back part: sequenced distance arithmetic, group averaging and the result register.
`default_nettype none

module epwr_back import epwr_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                q_valid,
  input  wire epwr_job_t           q_job,
  output logic                     q_pop,
  input  wire logic [PERIOD_W-1:0] timer_period,
  input  wire logic [SCALE_W-1:0]  distance_scale,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output epwr_out_t                out_data
);

  localparam int ST_W = 4;
  localparam logic [ST_W-1:0] S_IDLE = 4'd0;
  localparam logic [ST_W-1:0] S_MUL  = 4'd1;
  localparam logic [ST_W-1:0] S_ADD  = 4'd2;
  localparam logic [ST_W-1:0] S_MLO  = 4'd3;
  localparam logic [ST_W-1:0] S_MHI  = 4'd4;
  localparam logic [ST_W-1:0] S_SUM  = 4'd5;
  localparam logic [ST_W-1:0] S_ACC  = 4'd6;
  localparam logic [ST_W-1:0] S_ALO  = 4'd7;
  localparam logic [ST_W-1:0] S_AHI  = 4'd8;
  localparam logic [ST_W-1:0] S_DIV  = 4'd9;
  localparam logic [ST_W-1:0] S_EMIT = 4'd10;

  logic [ST_W-1:0]               state_r, state_nxt;
  logic [SUM_W-1:0]              sum_r, sum_nxt;
  logic [SCNT_W-1:0]             scnt_r, scnt_nxt;
  logic                          out_valid_r, out_valid_nxt;
  epwr_job_t                     job_r, job_nxt;
  logic [TOTAL_W-1:0]            prod1_r, prod1_nxt;
  logic [TOTAL_W-1:0]            total_r, total_nxt;
  logic [TOTAL_LO_W+SCALE_W-1:0] plo_r, plo_nxt;
  logic [TOTAL_HI_W+SCALE_W-1:0] phi_r, phi_nxt;
  logic [DIST_W-1:0]             dist_r, dist_nxt;
  logic                          tmo_r, tmo_nxt;
  logic                          avg_vld_r, avg_vld_nxt;
  logic [SUM_W-1:0]              quo_r, quo_nxt;
  logic [SUM_LO_W+RECIP_W-1:0]   alo_r, alo_nxt;
  logic [SUM_HI_W+RECIP_W-1:0]   ahi_r, ahi_nxt;
  epwr_out_t                     out_r, out_nxt;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    logic [WEIGHT_W-1:0]               weight;
    logic [OVERFLOW_BITS+WEIGHT_W-1:0] mul1_full;
    logic [PROD_W-1:0]                 prod;
    logic [WIDE_W-1:0]                 dist_wide;
    logic [SUM_W-1:0]                  sum_new;
    logic [SCNT_W-1:0]                 scnt_inc;
    logic [AVG_PROD_W-1:0]             avg_prod;
    weight    = WEIGHT_W'(timer_period[COUNTER_WIDTH-1:0]) + 1'b1;
    mul1_full = job_r.ovf_count * weight;
    prod      = (PROD_W'(phi_r) << TOTAL_LO_W) + PROD_W'(plo_r);
    dist_wide = WIDE_W'(prod >> FRAC_W);
    sum_new   = sum_r + SUM_W'(dist_r);
    scnt_inc  = scnt_r + 1'b1;
    avg_prod  = (AVG_PROD_W'(ahi_r) << SUM_LO_W) + AVG_PROD_W'(alo_r);

    state_nxt     = state_r;
    sum_nxt       = sum_r;
    scnt_nxt      = scnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    job_nxt       = job_r;
    prod1_nxt     = prod1_r;
    total_nxt     = total_r;
    plo_nxt       = plo_r;
    phi_nxt       = phi_r;
    dist_nxt      = dist_r;
    tmo_nxt       = tmo_r;
    avg_vld_nxt   = avg_vld_r;
    quo_nxt       = quo_r;
    alo_nxt       = alo_r;
    ahi_nxt       = ahi_r;
    out_nxt       = out_r;
    q_pop         = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          job_nxt = q_job;
          if (q_job.timeout) begin
            dist_nxt  = DIST_MAX;
            tmo_nxt   = 1'b1;
            state_nxt = S_ACC;
          end else begin
            tmo_nxt   = 1'b0;
            state_nxt = S_MUL;
          end
        end
      end
      S_MUL: begin
        prod1_nxt = mul1_full[TOTAL_W-1:0];
        state_nxt = S_ADD;
      end
      S_ADD: begin
        total_nxt = prod1_r + TOTAL_W'(job_r.capture);
        state_nxt = S_MLO;
      end
      S_MLO: begin
        plo_nxt   = total_r[TOTAL_LO_W-1:0] * distance_scale;
        state_nxt = S_MHI;
      end
      S_MHI: begin
        phi_nxt   = total_r[TOTAL_W-1:TOTAL_LO_W] * distance_scale;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        if (dist_wide > WIDE_W'(DIST_MAX)) begin
          dist_nxt = DIST_MAX;
        end else begin
          dist_nxt = dist_wide[DIST_W-1:0];
        end
        state_nxt = S_ACC;
      end
      S_ACC: begin
        if (scnt_inc == SCNT_W'(AVERAGE_COUNT)) begin
          quo_nxt     = sum_new;
          sum_nxt     = '0;
          scnt_nxt    = '0;
          avg_vld_nxt = 1'b1;
          state_nxt   = S_ALO;
        end else begin
          sum_nxt     = sum_new;
          scnt_nxt    = scnt_inc;
          avg_vld_nxt = 1'b0;
          state_nxt   = S_EMIT;
        end
      end
      S_ALO: begin
        // The group sum is multiplied by the reciprocal in two halves.
        alo_nxt   = quo_r[SUM_LO_W-1:0] * AVG_RECIP;
        state_nxt = S_AHI;
      end
      S_AHI: begin
        ahi_nxt   = quo_r[SUM_W-1:SUM_LO_W] * AVG_RECIP;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        quo_nxt   = SUM_W'(avg_prod >> AVG_SHIFT);
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt         = 1'b1;
          out_nxt.distance      = dist_r;
          out_nxt.timed_out     = tmo_r;
          out_nxt.average       = avg_vld_r ? quo_r[DIST_W-1:0] : '0;
          out_nxt.average_valid = avg_vld_r;
          state_nxt             = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sum_r       <= '0;
      scnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      scnt_r      <= scnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r     <= job_nxt;
    prod1_r   <= prod1_nxt;
    total_r   <= total_nxt;
    plo_r     <= plo_nxt;
    phi_r     <= phi_nxt;
    dist_r    <= dist_nxt;
    tmo_r     <= tmo_nxt;
    avg_vld_r <= avg_vld_nxt;
    quo_r     <= quo_nxt;
    alo_r     <= alo_nxt;
    ahi_r     <= ahi_nxt;
    out_r     <= out_nxt;
  end

  a_timeout_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.timed_out) |-> (out_r.distance == DIST_MAX))
    else $error("timed-out result without saturated distance");

  a_average_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.average_valid) |-> (out_r.average == '0))
    else $error("average not zero outside a completed group");

  a_emit_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && !out_valid_r) |=> (out_valid_r && state_r == S_IDLE))
    else $error("result not loaded into a free output register");

  a_div_flagged: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (avg_vld_r && scnt_r == '0))
    else $error("averaging division outside a completed group");

endmodule

`default_nettype wire

// ===== sv/echo_pulse_width_ranger_core.sv =====
// Top level of the echo pulse width ranger: configuration registers and the three parts.
//
// Usage: timer events arrive on the in_ channel (in_valid, in_stall, in_data) as a
// command (none, overflow, capture edge, or overflow then edge) with the captured count.
// The first edge arms a measurement, overflows while armed are counted, and an
// edge while armed or an overflow past the largest count finishes it. Each finished
// measurement leaves on the out_ channel (out_valid, out_stall, out_data) as one
// transfer carrying the distance in centimeters, the timeout flag and, on every
// third result, the mean of the group. Events that finish nothing give no transfer.
// Sequence: the back weights the overflow count, adds the capture, scales in two halves
// and saturates (a timeout skips these), books the group sum, forms a completed group's
// mean from a reciprocal multiply in two halves, and loads the output register.
// Throughput: the front takes one event per cycle while the two-entry job queue has
// room; the back sequences its multiplies and takes a new job only when idle.
// When the receiver stalls, the result waits in the output register, the back holds
// its next result, the queue fills, and then in_stall rises.
// Reset (rst_n low at a clock edge) disarms the measurement, clears the group sum,
// empties the queue and the output, and restores timer_period to all ones and
// distance_scale to 1114. The user is to write configuration only while the block is
// idle; the block itself does not enforce it.
`default_nettype none

module echo_pulse_width_ranger_core import epwr_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire epwr_in_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output epwr_out_t                  out_data,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers; the back part reads them while it computes.
  logic [PERIOD_W-1:0] timer_period_r, timer_period_nxt;
  logic [SCALE_W-1:0]  distance_scale_r, distance_scale_nxt;

  // Front to queue, queue to back.
  logic      q_push;
  epwr_job_t q_push_job;
  logic      q_full;
  logic      q_pop;
  logic      q_not_empty;
  epwr_job_t q_head_job;

  always_comb begin
    timer_period_nxt   = timer_period_r;
    distance_scale_nxt = distance_scale_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_TIMER_PERIOD:   timer_period_nxt = cfg_data[PERIOD_W-1:0];
        REG_DISTANCE_SCALE: distance_scale_nxt = cfg_data[SCALE_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timer_period_r   <= PERIOD_RESET;
      distance_scale_r <= SCALE_RESET;
    end else begin
      timer_period_r   <= timer_period_nxt;
      distance_scale_r <= distance_scale_nxt;
    end
  end

  // The front classifies each event and updates arming and the overflow count.
  epwr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (q_push_job)
  );

  // Finished measurements wait here so that the front keeps taking events.
  epwr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_job  (q_push_job),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_job  (q_head_job)
  );

  // The back computes the distance, keeps the group sum and drives the result.
  epwr_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_not_empty),
    .q_job          (q_head_job),
    .q_pop          (q_pop),
    .timer_period   (timer_period_r),
    .distance_scale (distance_scale_r),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data)
  );

endmodule

`default_nettype wire

// ===== tb/tb_echo_pulse_width_ranger_core.sv =====
// Self-checking testbench for the echo pulse width ranger core.
`default_nettype none

module tb_echo_pulse_width_ranger_core;
  import epwr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // The slowest result is a measurement that completes a group; the settle time after
  // the last result leaves the block fully idle before a write.
  localparam int SETTLE_CYCLES = 60;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int MAX_REPORTS   = 10;

  // Shapes of event sequences used by the random part of the run.
  typedef enum {SEQ_RANDOM, SEQ_SHORT, SEQ_LONG, SEQ_TIMEOUT, SEQ_NOISE} echo_seq_t;

  // Tracks the ranger's state and configuration, predicts the result of each
  // accepted event and checks every result transfer against the oldest prediction.
  class echo_range_tracker;
    logic [PERIOD_W-1:0]      timer_period;
    logic [SCALE_W-1:0]       distance_scale;
    bit                       armed;
    logic [OVERFLOW_BITS-1:0] ovf_count;
    int unsigned              group_fill;
    logic [63:0]              group_sum;
    epwr_out_t                pending_ranges[$];
    int unsigned              failures;
    int unsigned              reports;
    int unsigned              measurements;
    int unsigned              timeouts;
    int unsigned              group_means;

    function new();
      timer_period   = PERIOD_RESET;
      distance_scale = SCALE_RESET;
      armed          = 1'b0;
      ovf_count      = '0;
      group_fill     = 0;
      group_sum      = '0;
      failures       = 0;
      reports        = 0;
      measurements   = 0;
      timeouts       = 0;
      group_means    = 0;
    endfunction

    function void set_config(logic [PERIOD_W-1:0] period, logic [SCALE_W-1:0] scale);
      timer_period   = period;
      distance_scale = scale;
    endfunction

    function int outstanding();
      return pending_ranges.size();
    endfunction

    // Books one finished measurement into the group and queues its result.
    function void finish_measurement(logic [DIST_W-1:0] range_cm, bit tmo);
      epwr_out_t r;
      r.distance      = range_cm;
      r.timed_out     = tmo;
      r.average       = '0;
      r.average_valid = 1'b0;
      group_sum  = group_sum + range_cm;
      group_fill = group_fill + 1;
      if (group_fill >= AVERAGE_COUNT) begin
        r.average       = DIST_W'(group_sum / AVERAGE_COUNT);
        r.average_valid = 1'b1;
        group_sum       = '0;
        group_fill      = 0;
      end
      armed     = 1'b0;
      ovf_count = '0;
      pending_ranges.push_back(r);
    endfunction

    function void note_event(epwr_in_t ev);
      bit          has_ovf;
      bit          has_edge;
      logic [63:0] weight;
      logic [63:0] total;
      logic [63:0] scaled;
      has_ovf  = (ev.command == CMD_OVERFLOW) || (ev.command == CMD_OVERFLOW_EDGE);
      has_edge = (ev.command == CMD_EDGE) || (ev.command == CMD_OVERFLOW_EDGE);
      if (has_ovf && armed) begin
        // The overflow past the largest count ends the echo; a paired edge is dropped.
        if (ovf_count == OVF_MAX) begin
          finish_measurement(DIST_MAX, 1'b1);
          return;
        end
        ovf_count = ovf_count + 1'b1;
      end
      if (has_edge) begin
        if (armed) begin
          weight = 64'(timer_period) + 64'd1;
          total  = 64'(ovf_count) * weight + 64'(ev.capture_value);
          scaled = (total * 64'(distance_scale)) >> FRAC_W;
          if (scaled > 64'(DIST_MAX))
            scaled = 64'(DIST_MAX);
          finish_measurement(DIST_W'(scaled), 1'b0);
          return;
        end
        armed     = 1'b1;
        ovf_count = '0;
      end
    endfunction

    function void check_range(epwr_out_t got);
      epwr_out_t want;
      if (pending_ranges.size() == 0) begin
        failures++;
        if (reports < MAX_REPORTS) begin
          reports++;
          $display("ERROR: result with nothing expected: dist=%0h tmo=%0b avg=%0h avg_vld=%0b",
                   got.distance, got.timed_out, got.average, got.average_valid);
        end
        return;
      end
      want = pending_ranges.pop_front();
      measurements++;
      if (want.timed_out)
        timeouts++;
      if (want.average_valid)
        group_means++;
      if (got.distance !== want.distance || got.timed_out !== want.timed_out ||
          got.average !== want.average || got.average_valid !== want.average_valid) begin
        failures++;
        if (reports < MAX_REPORTS) begin
          reports++;
          $display("ERROR: result %0d mismatch", measurements);
          $display("  expected dist=%0h tmo=%0b avg=%0h avg_vld=%0b",
                   want.distance, want.timed_out, want.average, want.average_valid);
          $display("  actual   dist=%0h tmo=%0b avg=%0h avg_vld=%0b",
                   got.distance, got.timed_out, got.average, got.average_valid);
        end
      end
    endfunction
  endclass

  // Clock, reset and the block's ports. Every input starts at a known value.
  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  epwr_in_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  epwr_out_t             out_data;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  echo_range_tracker sb = new();

  // When set, neither side inserts idle or stall cycles any more.
  bit          no_idle     = 1'b0;
  int unsigned events_sent = 0;
  int unsigned cycle_count = 0;

  echo_pulse_width_ranger_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // A hard cycle limit catches a hung handshake or a result that never arrives.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("ERROR: run stopped after %0d cycles with %0d results outstanding",
               cycle_count, sb.outstanding());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result side. Values read right after the edge are the ones the block saw at that
  // edge, so a transfer is recognized exactly when out_valid was high and out_stall
  // low. Stall is then driven in random bursts.
  initial begin : result_side
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall)
        sb.check_range(out_data);
      if (stall_left > 0) begin
        stall_left--;
        if (stall_left == 0)
          out_stall <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 6);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Returns a capture value that favors the ends of the range.
  function automatic logic [CAPTURE_W-1:0] rand_capture();
    unique case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return CAPTURE_W'($urandom_range(0, 255));
      default: return CAPTURE_W'($urandom);
    endcase
  endfunction

  function automatic epwr_in_t make_event(logic [CMD_W-1:0] cmd, logic [CAPTURE_W-1:0] cap);
    epwr_in_t ev;
    ev.command       = cmd;
    ev.capture_value = cap;
    return ev;
  endfunction

  // Offers one event and waits for its transfer. The valid line stays high afterward
  // so that back-to-back events go out on consecutive cycles; anything that pauses
  // the sender lowers it first.
  task automatic send_event(epwr_in_t ev);
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= ev;
    do @(posedge clk); while (in_stall);
    sb.note_event(ev);
    if (ev.command != CMD_NONE)
      events_sent++;
  endtask

  // Holds the sender off until every predicted result has been transferred.
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.outstanding() != 0);
  endtask

  // Drains the block, lets the last group mean settle, then loads both registers.
  // The unused upper bits of the scale write carry random data.
  task automatic load_ranger_config(logic [PERIOD_W-1:0] period, logic [SCALE_W-1:0] scale);
    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_TIMER_PERIOD;
    cfg_data  <= period;
    @(posedge clk);
    cfg_index <= REG_DISTANCE_SCALE;
    cfg_data  <= {16'($urandom), scale};
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_config(period, scale);
  endtask

  // One measurement or burst of noise. For long and timeout echoes, alt picks how
  // the last step is formed: through a combined overflow-and-edge event or not.
  task automatic run_sequence(echo_seq_t kind, bit alt);
    int unsigned n_ovf;
    unique case (kind)
      SEQ_SHORT: begin
        // An idle overflow-and-edge arms just like a plain edge.
        send_event(make_event($urandom_range(0, 1) ? CMD_EDGE : CMD_OVERFLOW_EDGE,
                              rand_capture()));
        n_ovf = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 3) : $urandom_range(4, 63);
        repeat (n_ovf) begin
          if ($urandom_range(0, 15) == 0)
            send_event(make_event(CMD_NONE, rand_capture()));
          send_event(make_event(CMD_OVERFLOW, rand_capture()));
        end
        send_event(make_event($urandom_range(0, 1) ? CMD_EDGE : CMD_OVERFLOW_EDGE,
                              rand_capture()));
      end
      SEQ_LONG: begin
        // The overflow count reaches its largest value and the edge still lands.
        send_event(make_event(CMD_EDGE, rand_capture()));
        repeat (OVF_MAX - 1) send_event(make_event(CMD_OVERFLOW, rand_capture()));
        if (alt) begin
          send_event(make_event(CMD_OVERFLOW_EDGE, rand_capture()));
        end else begin
          send_event(make_event(CMD_OVERFLOW, rand_capture()));
          send_event(make_event(CMD_EDGE, rand_capture()));
        end
      end
      SEQ_TIMEOUT: begin
        // One overflow too many; with the combined event its edge is dropped.
        send_event(make_event(CMD_EDGE, rand_capture()));
        repeat (OVF_MAX) send_event(make_event(CMD_OVERFLOW, rand_capture()));
        send_event(make_event(alt ? CMD_OVERFLOW_EDGE : CMD_OVERFLOW, rand_capture()));
      end
      default: begin
        repeat ($urandom_range(1, 3))
          send_event(make_event(CMD_W'($urandom_range(0, 3)), rand_capture()));
      end
    endcase
  endtask

  // Random events under one configuration until the budget of events is used up.
  task automatic run_phase(int unsigned budget, echo_seq_t forced, bit forced_alt);
    int unsigned start;
    int unsigned pick;
    start = events_sent;
    if (forced != SEQ_RANDOM)
      run_sequence(forced, forced_alt);
    while (events_sent - start < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 70)
        run_sequence(SEQ_SHORT, 1'b0);
      else if (pick < 74)
        run_sequence(SEQ_LONG, pick[0]);
      else if (pick < 76)
        run_sequence(SEQ_TIMEOUT, pick[0]);
      else
        run_sequence(SEQ_NOISE, 1'b0);
      // Now and then the sender waits for the block to empty completely.
      if ($urandom_range(0, 19) == 0)
        wait_results_drained();
    end
  endtask

  initial begin : stimulus
    // Reset is held from time zero and released once.
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed events under the reset configuration.
    send_event(make_event(CMD_OVERFLOW, rand_capture()));      // overflow while idle
    send_event(make_event(CMD_NONE, rand_capture()));          // no event
    send_event(make_event(CMD_EDGE, rand_capture()));          // arm
    send_event(make_event(CMD_EDGE, '0));                      // zero width echo
    send_event(make_event(CMD_EDGE, '0));
    send_event(make_event(CMD_EDGE, '1));                      // largest capture
    send_event(make_event(CMD_EDGE, rand_capture()));
    send_event(make_event(CMD_OVERFLOW_EDGE, 32'd100));        // overflow counted first
    send_event(make_event(CMD_OVERFLOW_EDGE, rand_capture())); // idle: only the edge arms
    send_event(make_event(CMD_NONE, rand_capture()));          // no event while armed
    send_event(make_event(CMD_OVERFLOW, rand_capture()));
    send_event(make_event(CMD_EDGE, rand_capture()));
    send_event(make_event(CMD_EDGE, rand_capture()));
    send_event(make_event(CMD_OVERFLOW, rand_capture()));
    send_event(make_event(CMD_OVERFLOW, rand_capture()));
    send_event(make_event(CMD_EDGE, '1));

    // Random phases over a spread of settings, the extremes among them.
    run_phase(50, SEQ_RANDOM, 1'b0);
    load_ranger_config('0, '1);
    run_phase(55, SEQ_RANDOM, 1'b0);
    load_ranger_config('1, '1);
    run_phase(70, SEQ_LONG, 1'b1);                   // saturated distance
    load_ranger_config(PERIOD_W'($urandom), '0);
    run_phase(55, SEQ_RANDOM, 1'b0);
    load_ranger_config('1, SCALE_RESET);
    run_phase(70, SEQ_TIMEOUT, 1'b0);
    load_ranger_config(PERIOD_W'($urandom_range(0, 1000)), SCALE_W'($urandom));
    run_phase(55, SEQ_RANDOM, 1'b0);
    load_ranger_config(PERIOD_W'($urandom), SCALE_W'($urandom));
    run_phase(70, SEQ_TIMEOUT, 1'b1);
    load_ranger_config(PERIOD_W'($urandom), SCALE_RESET);
    // The last phase runs with both sides at full rate.
    no_idle = 1'b1;
    run_phase(55, SEQ_RANDOM, 1'b0);

    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d timer events across 8 settings of period and scale in %0d cycles.",
             events_sent, cycle_count);
    $display("Checked %0d measurements: %0d timeouts and %0d group means.",
             sb.measurements, sb.timeouts, sb.group_means);
    if (sb.failures == 0 && sb.outstanding() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d failures, %0d results never arrived", sb.failures, sb.outstanding());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
